// ===== rtl/core/dupd_pkg.sv =====
// Shared constants, types and character decode functions for the data URI payload decoder.
package dupd_pkg;

  typedef logic [1:0] status_t;
  localparam status_t ST_RUNNING = 2'd0;
  localparam status_t ST_OK      = 2'd1;
  localparam status_t ST_FAILED  = 2'd2;

  typedef logic [0:0] cfg_index_t;
  localparam cfg_index_t REG_DECODE_MODE = 1'b0;
  localparam cfg_index_t REG_MAX_OUT     = 1'b1;

  localparam logic MODE_PERCENT = 1'b0;
  localparam logic MODE_BASE64  = 1'b1;

  typedef logic [1:0] phase_t;
  localparam phase_t PH_0 = 2'd0;
  localparam phase_t PH_1 = 2'd1;
  localparam phase_t PH_2 = 2'd2;
  localparam phase_t PH_3 = 2'd3;

  localparam int HELD_BITS = 18;
  localparam int MAX_BITS  = 24;
  localparam logic [MAX_BITS-1:0] MAX_OUT_RESET = 24'hFFFFFF;

  localparam logic [7:0] CHAR_CTRL_LIMIT = 8'h20;
  localparam logic [7:0] CHAR_DEL        = 8'h7F;
  localparam logic [7:0] CHAR_PERCENT    = 8'h25;
  localparam logic [7:0] CHAR_PAD        = 8'h3D;

  // Bit 4 set marks a character that is not a hex digit.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b0, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b0, 4'(c - 8'h37)};
    return r;
  endfunction

  // Bit 6 set marks a character outside the base64 alphabet.
  function automatic logic [6:0] sextet(input logic [7:0] c);
    logic [6:0] r;
    r = 7'h40;
    if (c >= 8'h41 && c <= 8'h5A) r = {1'b0, 6'(c - 8'h41)};
    else if (c >= 8'h61 && c <= 8'h7A) r = {1'b0, 6'(c - 8'h47)};
    else if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 6'(c + 8'h04)};
    else if (c == 8'h2B) r = 7'd62;
    else if (c == 8'h2F) r = 7'd63;
    return r;
  endfunction

endpackage

// ===== rtl/core/data_uri_payload_decoder.sv =====
// Top level of the data URI payload decoder: percent and base64 decode with byte limit.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one payload character per word,
//   char_code, with is_final set on the last character of the payload.
//   Output channel (out_valid / out_stall) returns exactly one word per input
//   word: data_byte with byte_valid, status (running, ok, failed) and run_end.
//   Status is non-zero only on the word of the final character; on failure the
//   consumer discards the bytes of that payload.
//   Configuration channel (cfg_valid / cfg_ready, always ready): index 0 sets
//   decode_mode (0 percent, 1 base64) and clears the run state; index 1 sets
//   max_out_bytes. Write only while the block is idle.
// Timing:
//   Output valid rises in the cycle after input acceptance. Throughput is
//   one word per cycle, set by the single output register; the input is
//   stalled only while that register holds a word and the receiver stalls.
// Reset:
//   rst clears the run state, sets percent mode and the largest byte limit.
module data_uri_payload_decoder #(
  parameter int COUNT_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        char_code,
  input  logic                              is_final,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        data_byte,
  output logic                              byte_valid,
  output dupd_pkg::status_t                 status,
  output logic                              run_end,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  dupd_pkg::cfg_index_t              cfg_index,
  input  logic [dupd_pkg::MAX_BITS-1:0]     cfg_data
);

  localparam int CMP_W = (COUNT_BITS > dupd_pkg::MAX_BITS) ? COUNT_BITS : dupd_pkg::MAX_BITS;

  logic                              decode_mode;
  logic [dupd_pkg::MAX_BITS-1:0]     max_out_bytes;
  dupd_pkg::phase_t                  group_phase, group_phase_next;
  logic [dupd_pkg::HELD_BITS-1:0]    held_bits, held_bits_next;
  logic                              pad_seen, pad_seen_next;
  logic [COUNT_BITS-1:0]             byte_count, byte_count_next;
  logic                              failed_flag, failed_flag_next;

  logic                              in_take;
  logic                              cfg_take;
  logic                              emit_req;
  logic [7:0]                        emit_val;
  logic                              res_valid;
  logic [7:0]                        res_data;
  dupd_pkg::status_t                 res_status;
  logic [4:0]                        hx;
  logic [6:0]                        sx;
  logic [dupd_pkg::HELD_BITS-1:0]    held_sh;
  logic                              over_limit;

  assign in_stall  = out_valid & out_stall;
  assign in_take   = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid & cfg_ready;
  assign run_end   = 1'b1;

  assign hx      = dupd_pkg::hex_nibble(char_code);
  assign sx      = dupd_pkg::sextet(char_code);
  assign held_sh = {held_bits[dupd_pkg::HELD_BITS-7:0], sx[5:0]};
  assign over_limit = (CMP_W'(byte_count) >= CMP_W'(max_out_bytes)) || (&byte_count);

  always_comb begin
    group_phase_next = group_phase;
    held_bits_next   = held_bits;
    pad_seen_next    = pad_seen;
    byte_count_next  = byte_count;
    failed_flag_next = failed_flag;
    emit_req         = 1'b0;
    emit_val         = char_code;
    res_valid        = 1'b0;
    res_data         = 8'h00;
    res_status       = dupd_pkg::ST_RUNNING;

    if (!failed_flag) begin
      if (char_code < dupd_pkg::CHAR_CTRL_LIMIT || char_code == dupd_pkg::CHAR_DEL) begin
        failed_flag_next = 1'b1;
      end else if (decode_mode == dupd_pkg::MODE_PERCENT) begin
        case (group_phase)
          dupd_pkg::PH_1: begin
            if (hx[4]) begin
              failed_flag_next = 1'b1;
            end else begin
              held_bits_next   = {{(dupd_pkg::HELD_BITS-4){1'b0}}, hx[3:0]};
              group_phase_next = dupd_pkg::PH_2;
            end
          end
          dupd_pkg::PH_2: begin
            if (hx[4]) begin
              failed_flag_next = 1'b1;
            end else begin
              group_phase_next = dupd_pkg::PH_0;
              emit_req         = 1'b1;
              emit_val         = {held_bits[3:0], hx[3:0]};
            end
          end
          default: begin
            group_phase_next = dupd_pkg::PH_0;
            if (char_code == dupd_pkg::CHAR_PERCENT) group_phase_next = dupd_pkg::PH_1;
            else emit_req = 1'b1;
          end
        endcase
      end else if (char_code == dupd_pkg::CHAR_PAD) begin
        case (group_phase)
          dupd_pkg::PH_2: begin
            if (held_bits[3:0] != 4'h0) begin
              failed_flag_next = 1'b1;
            end else begin
              pad_seen_next    = 1'b1;
              group_phase_next = dupd_pkg::PH_3;
            end
          end
          dupd_pkg::PH_3: begin
            if ((pad_seen && !is_final) || (!pad_seen && held_bits[1:0] != 2'b00)) begin
              failed_flag_next = 1'b1;
            end else begin
              pad_seen_next    = 1'b0;
              group_phase_next = dupd_pkg::PH_0;
            end
          end
          default: failed_flag_next = 1'b1;
        endcase
      end else if (sx[6] || (group_phase == dupd_pkg::PH_3 && pad_seen)) begin
        failed_flag_next = 1'b1;
      end else begin
        held_bits_next = held_sh;
        case (group_phase)
          dupd_pkg::PH_0: group_phase_next = dupd_pkg::PH_1;
          dupd_pkg::PH_1: begin
            group_phase_next = dupd_pkg::PH_2;
            emit_req         = 1'b1;
            emit_val         = held_sh[11:4];
          end
          dupd_pkg::PH_2: begin
            group_phase_next = dupd_pkg::PH_3;
            emit_req         = 1'b1;
            emit_val         = held_sh[9:2];
          end
          default: begin
            group_phase_next = dupd_pkg::PH_0;
            pad_seen_next    = 1'b0;
            emit_req         = 1'b1;
            emit_val         = held_sh[7:0];
          end
        endcase
      end
    end

    if (emit_req) begin
      if (over_limit) begin
        failed_flag_next = 1'b1;
      end else begin
        byte_count_next = byte_count + COUNT_BITS'(1);
        res_valid       = 1'b1;
        res_data        = emit_val;
      end
    end

    if (failed_flag_next) begin
      res_valid = 1'b0;
      res_data  = 8'h00;
    end

    if (is_final) begin
      res_status = (failed_flag_next || group_phase_next != dupd_pkg::PH_0) ?
                   dupd_pkg::ST_FAILED : dupd_pkg::ST_OK;
      group_phase_next = dupd_pkg::PH_0;
      held_bits_next   = '0;
      pad_seen_next    = 1'b0;
      byte_count_next  = '0;
      failed_flag_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode   <= dupd_pkg::MODE_PERCENT;
      max_out_bytes <= dupd_pkg::MAX_OUT_RESET;
      group_phase   <= dupd_pkg::PH_0;
      held_bits     <= '0;
      pad_seen      <= 1'b0;
      byte_count    <= '0;
      failed_flag   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_take && cfg_index == dupd_pkg::REG_DECODE_MODE) begin
        decode_mode <= cfg_data[0];
        group_phase <= dupd_pkg::PH_0;
        held_bits   <= '0;
        pad_seen    <= 1'b0;
        byte_count  <= '0;
        failed_flag <= 1'b0;
      end else if (in_take) begin
        group_phase <= group_phase_next;
        held_bits   <= held_bits_next;
        pad_seen    <= pad_seen_next;
        byte_count  <= byte_count_next;
        failed_flag <= failed_flag_next;
      end
      if (cfg_take && cfg_index == dupd_pkg::REG_MAX_OUT) begin
        max_out_bytes <= cfg_data;
      end
      if (in_take) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the result word until the receiver takes it.
  always_ff @(posedge clk) begin
    if (in_take) begin
      data_byte  <= res_data;
      byte_valid <= res_valid;
      status     <= res_status;
    end
  end

`ifndef SYNTH
  a_zero_without_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |-> (data_byte == 8'h00))
    else $error("data_byte not zero on a word without a decoded byte");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output register");

  a_final_clears_run: assert property (@(posedge clk) disable iff (rst)
    (in_take && is_final && !cfg_take) |=>
      (group_phase == dupd_pkg::PH_0 && byte_count == '0 && !failed_flag && !pad_seen))
    else $error("run state not cleared after final character");
`endif

endmodule
